// ===== rtl/core/xgcd_pkg.sv =====
// Package for the extended GCD block: shared widths and the command and
// status bundles between the controller and the datapath.
// No dependencies.
package xgcd_pkg;

   // Width of the operand and divisor ports.
   localparam int FIELD_BITS = 31;
   // Width of the Bezout coefficient ports; coefficients wrap modulo 2^32.
   localparam int COEFF_BITS = 32;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // Capture a new item and set the initial coefficients.
      logic div_init;   // Clear the partial remainder and the quotient products.
      logic div_step;   // Retire one quotient bit.
      logic update;     // Shift the remainder and coefficient pairs.
      logic out_load;   // Copy the finished result into the output register.
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cur_zero;   // The current remainder is zero, so the loop ends.
      logic count_last; // The division is on its last quotient bit.
   } sts_type;

endpackage

// ===== rtl/core/xgcd_dpath.sv =====
// Datapath of the extended GCD block: remainder and coefficient registers,
// a restoring divider that retires one quotient bit per cycle, and the
// output register. Depends on xgcd_pkg.
module xgcd_dpath
   import xgcd_pkg::*;
#(
   parameter int OPERAND_BITS = 31
) (
   input  logic                  clock,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [FIELD_BITS-1:0] op_a,
   input  logic [FIELD_BITS-1:0] op_b,
   output logic [FIELD_BITS-1:0] res_divisor,
   output logic [COEFF_BITS-1:0] res_coeff_a,
   output logic [COEFF_BITS-1:0] res_coeff_b
);

   localparam int W  = OPERAND_BITS;
   localparam int CW = $clog2(W);

   logic [W-1:0]          rprev_ff, rprev_in;
   logic [W-1:0]          rcur_ff, rcur_in;
   logic [W-1:0]          part_ff, part_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [COEFF_BITS-1:0] sprev_ff, sprev_in, scur_ff, scur_in;
   logic [COEFF_BITS-1:0] tprev_ff, tprev_in, tcur_ff, tcur_in;
   logic [COEFF_BITS-1:0] accs_ff, accs_in, acct_ff, acct_in;
   logic [FIELD_BITS-1:0] odiv_ff, odiv_in;
   logic [COEFF_BITS-1:0] osa_ff, osa_in, osb_ff, osb_in;

   logic [63:0]  opa_ext, opb_ext, div_ext;
   logic [W:0]   part_sh, part_sub;
   logic         fits;
   logic [W-1:0] part_nx;
   logic [COEFF_BITS-1:0] accs_nx, acct_nx;

   // Operands are cut to the operand width; the divisor leaves at port width.
   assign opa_ext = 64'(op_a);
   assign opb_ext = 64'(op_b);
   assign div_ext = 64'(rprev_ff);

   // One restoring division step: the dividend shifts out of the previous
   // remainder register, MSB first.
   assign part_sh  = {part_ff, rprev_ff[W-1]};
   assign fits     = part_sh >= {1'b0, rcur_ff};
   assign part_sub = part_sh - {1'b0, rcur_ff};
   assign part_nx  = fits ? part_sub[W-1:0] : part_sh[W-1:0];

   // The quotient times each current coefficient is built up in Horner form
   // as the quotient bits arrive, so no multiplier is needed.
   assign accs_nx = {accs_ff[COEFF_BITS-2:0], 1'b0} + (fits ? scur_ff : '0);
   assign acct_nx = {acct_ff[COEFF_BITS-2:0], 1'b0} + (fits ? tcur_ff : '0);

   // Next-state selection for the datapath registers.
   always_comb begin
      rprev_in = rprev_ff;
      rcur_in  = rcur_ff;
      part_in  = part_ff;
      cnt_in   = cnt_ff;
      sprev_in = sprev_ff;
      scur_in  = scur_ff;
      tprev_in = tprev_ff;
      tcur_in  = tcur_ff;
      accs_in  = accs_ff;
      acct_in  = acct_ff;
      odiv_in  = odiv_ff;
      osa_in   = osa_ff;
      osb_in   = osb_ff;
      priority if (cmd.load) begin
         rprev_in = opa_ext[W-1:0];
         rcur_in  = opb_ext[W-1:0];
         sprev_in = COEFF_BITS'(1);
         scur_in  = '0;
         tprev_in = '0;
         tcur_in  = COEFF_BITS'(1);
      end else if (cmd.div_init) begin
         part_in = '0;
         accs_in = '0;
         acct_in = '0;
         cnt_in  = CW'(W - 1);
      end else if (cmd.div_step) begin
         part_in  = part_nx;
         rprev_in = {rprev_ff[W-2:0], 1'b0};
         accs_in  = accs_nx;
         acct_in  = acct_nx;
         cnt_in   = cnt_ff - CW'(1);
      end else if (cmd.update) begin
         rprev_in = rcur_ff;
         rcur_in  = part_ff;
         sprev_in = scur_ff;
         scur_in  = sprev_ff - accs_ff;
         tprev_in = tcur_ff;
         tcur_in  = tprev_ff - acct_ff;
      end else if (cmd.out_load) begin
         odiv_in = div_ext[FIELD_BITS-1:0];
         osa_in  = sprev_ff;
         osb_in  = tprev_ff;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      rprev_ff <= rprev_in;
      rcur_ff  <= rcur_in;
      part_ff  <= part_in;
      cnt_ff   <= cnt_in;
      sprev_ff <= sprev_in;
      scur_ff  <= scur_in;
      tprev_ff <= tprev_in;
      tcur_ff  <= tcur_in;
      accs_ff  <= accs_in;
      acct_ff  <= acct_in;
      odiv_ff  <= odiv_in;
      osa_ff   <= osa_in;
      osb_ff   <= osb_in;
   end

   // Status back to the controller.
   assign sts.cur_zero   = (rcur_ff == '0);
   assign sts.count_last = (cnt_ff == '0);

   assign res_divisor = odiv_ff;
   assign res_coeff_a = osa_ff;
   assign res_coeff_b = osb_ff;

endmodule

// ===== rtl/core/xgcd_ctrl.sv =====
// Controller of the extended GCD block: sequences load, division, update
// and output, and owns the input and result handshakes.
// Depends on xgcd_pkg.
module xgcd_ctrl
   import xgcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       ovalid_ff, ovalid_in;
   logic       req_take, rsp_take, out_free;

   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign rsp_take  = ovalid_ff && !rsp_stall;
   assign out_free  = !ovalid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = ovalid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.cur_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.count_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result register is full from its load until the item is taken.
   always_comb begin
      ovalid_in = ovalid_ff;
      if (cmd.out_load) begin
         ovalid_in = 1'b1;
      end else if (rsp_take) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
   end

endmodule

// ===== rtl/core/extended_gcd_bezout.sv =====
// Extended GCD with Bezout coefficients. For each item (value_a, value_b) the
// block returns divisor = gcd(a, b) and coeff_a, coeff_b with
// coeff_a*a + coeff_b*b = divisor, the coefficients in 32-bit two's complement
// (wrapping for operands wider than 31 bits). Operands are first cut to
// OPERAND_BITS bits. If b is zero the result is (a, 1, 0); if only a is zero it
// is (b, 0, 1). One item is worked on at a time: each Euclid step runs the
// restoring divider, which retires one quotient bit per cycle, and then
// updates the remainder and coefficient pairs. A finished result waits in an
// output register; the next item is accepted while it waits. Depends on
// xgcd_pkg, xgcd_ctrl and xgcd_dpath.
module extended_gcd_bezout
   import xgcd_pkg::*;
#(
   parameter int OPERAND_BITS = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [FIELD_BITS-1:0]        req_value_a,
   input  logic [FIELD_BITS-1:0]        req_value_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [FIELD_BITS-1:0]        rsp_divisor,
   output logic signed [COEFF_BITS-1:0] rsp_coeff_a,
   output logic signed [COEFF_BITS-1:0] rsp_coeff_b
);

   cmd_type               cmd;
   sts_type               sts;
   logic [COEFF_BITS-1:0] coeff_a_raw, coeff_b_raw;

   // Sequencer and handshakes.
   xgcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Remainders, coefficients, divider and output register.
   xgcd_dpath #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_dpath (
      .clock       (clock),
      .cmd         (cmd),
      .sts         (sts),
      .op_a        (req_value_a),
      .op_b        (req_value_b),
      .res_divisor (rsp_divisor),
      .res_coeff_a (coeff_a_raw),
      .res_coeff_b (coeff_b_raw)
   );

   assign rsp_coeff_a = $signed(coeff_a_raw);
   assign rsp_coeff_b = $signed(coeff_b_raw);

endmodule

// ===== sim/bezout_checker.sv =====
// Checker for the extended GCD block: watches both item channels, predicts the
// gcd and Bezout coefficients of every accepted request and compares responses.
// Depends on xgcd_pkg for the field widths.
`timescale 1ns / 1ps

module bezout_checker
   import xgcd_pkg::*;
#(
   parameter int OPERAND_BITS = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [FIELD_BITS-1:0]        req_value_a,
   input  logic [FIELD_BITS-1:0]        req_value_b,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [FIELD_BITS-1:0]        rsp_divisor,
   input  logic signed [COEFF_BITS-1:0] rsp_coeff_a,
   input  logic signed [COEFF_BITS-1:0] rsp_coeff_b,
   output int                           mismatch_count,
   output int                           outstanding_items
);

   // One expected response: the gcd and its two coefficients.
   typedef struct packed {
      logic [FIELD_BITS-1:0]        divisor;
      logic signed [COEFF_BITS-1:0] coeff_a;
      logic signed [COEFF_BITS-1:0] coeff_b;
   } bezout_triple_type;

   // Expected responses, oldest first.
   bezout_triple_type bezout_queue[$];

   // Iterative extended Euclid. Coefficients wrap modulo 2^64 and only the
   // low bits are kept, which is exact for operands up to 31 bits.
   function automatic bezout_triple_type compute_bezout(input logic [FIELD_BITS-1:0] a,
                                                        input logic [FIELD_BITS-1:0] b);
      logic [63:0] mask;
      logic [63:0] rem_prev, rem_cur, rem_next, quot;
      logic [63:0] sa_prev, sa_cur, sa_next;
      logic [63:0] sb_prev, sb_cur, sb_next;
      bezout_triple_type triple;
      mask = (OPERAND_BITS >= 64) ? '1 : ((64'd1 << OPERAND_BITS) - 64'd1);
      rem_prev = 64'(a) & mask;
      rem_cur  = 64'(b) & mask;
      sa_prev  = 64'd1;
      sa_cur   = 64'd0;
      sb_prev  = 64'd0;
      sb_cur   = 64'd1;
      while (rem_cur != 64'd0) begin
         quot     = rem_prev / rem_cur;
         rem_next = rem_prev - quot * rem_cur;
         sa_next  = sa_prev - quot * sa_cur;
         sb_next  = sb_prev - quot * sb_cur;
         rem_prev = rem_cur;
         rem_cur  = rem_next;
         sa_prev  = sa_cur;
         sa_cur   = sa_next;
         sb_prev  = sb_cur;
         sb_cur   = sb_next;
      end
      triple.divisor = rem_prev[FIELD_BITS-1:0];
      triple.coeff_a = sa_prev[COEFF_BITS-1:0];
      triple.coeff_b = sb_prev[COEFF_BITS-1:0];
      return triple;
   endfunction

   // Sample both channels at the clock edge. A response is matched before the
   // request of the same edge is queued, so a response can never match an
   // item accepted in the same cycle.
   always @(posedge clock) begin : channel_monitor
      bezout_triple_type want;
      int errors;
      errors = 0;
      if (reset) begin
         bezout_queue.delete();
         mismatch_count    <= 0;
         outstanding_items <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (bezout_queue.size() == 0) begin
               $error("unexpected response item: divisor %0d, coeff_a %0d, coeff_b %0d",
                      rsp_divisor, $signed(rsp_coeff_a), $signed(rsp_coeff_b));
               errors++;
            end else begin
               want = bezout_queue.pop_front();
               if (rsp_divisor !== want.divisor) begin
                  $error("divisor: expected %0d, got %0d", want.divisor, rsp_divisor);
                  errors++;
               end
               if (rsp_coeff_a !== want.coeff_a) begin
                  $error("coeff_a: expected %0d, got %0d",
                         $signed(want.coeff_a), $signed(rsp_coeff_a));
                  errors++;
               end
               if (rsp_coeff_b !== want.coeff_b) begin
                  $error("coeff_b: expected %0d, got %0d",
                         $signed(want.coeff_b), $signed(rsp_coeff_b));
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            bezout_queue.push_back(compute_bezout(req_value_a, req_value_b));
         end
         mismatch_count    <= mismatch_count + errors;
         outstanding_items <= bezout_queue.size();
      end
   end

endmodule

// ===== sim/extended_gcd_bezout_test.sv =====
// Testbench top for the extended GCD block: drives directed and random operand
// pairs under several idling patterns and gives the verdict.
// Depends on xgcd_pkg, extended_gcd_bezout and bezout_checker.
`timescale 1ns / 1ps

module extended_gcd_bezout_test;
   import xgcd_pkg::*;

   localparam int WATCHDOG_LIMIT         = 20000;
   localparam int DRAIN_CYCLES           = 1700;
   localparam int RANDOM_ITEMS_PER_PHASE = 87;
   localparam int PHASE_COUNT            = 4;
   localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

   // Operand mixes for the random part.
   typedef enum int {
      MIX_WIDE,
      MIX_NARROW,
      MIX_SHARED,
      MIX_FIBONACCI,
      MIX_ZERO,
      MIX_POWER,
      MIX_CLOSE
   } operand_mix_type;

   logic                         clock;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   logic                         req_stall;
   logic [FIELD_BITS-1:0]        req_value_a = '0;
   logic [FIELD_BITS-1:0]        req_value_b = '0;
   logic                         rsp_valid;
   logic                         rsp_stall   = 1'b0;
   logic [FIELD_BITS-1:0]        rsp_divisor;
   logic signed [COEFF_BITS-1:0] rsp_coeff_a;
   logic signed [COEFF_BITS-1:0] rsp_coeff_b;

   int mismatch_count;
   int outstanding_items;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int idle_cycles    = 0;
   int sender_idle_by_phase[PHASE_COUNT]   = '{0, 62, 0, 21};
   int receiver_stall_by_phase[PHASE_COUNT] = '{0, 0, 62, 21};
   longint unsigned fib[0:46];

   extended_gcd_bezout dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_value_a (req_value_a),
      .req_value_b (req_value_b),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_divisor (rsp_divisor),
      .rsp_coeff_a (rsp_coeff_a),
      .rsp_coeff_b (rsp_coeff_b)
   );

   bezout_checker bezout_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_value_a       (req_value_a),
      .req_value_b       (req_value_b),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_divisor       (rsp_divisor),
      .rsp_coeff_a       (rsp_coeff_a),
      .rsp_coeff_b       (rsp_coeff_b),
      .mismatch_count    (mismatch_count),
      .outstanding_items (outstanding_items)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog: too many cycles in a row with no item moving on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request item, idling first at the sender's rate, and return at
   // the edge that accepts it. Valid stays high for a following item.
   task automatic send_item(input logic [FIELD_BITS-1:0] a, input logic [FIELD_BITS-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_value_a <= a;
      req_value_b <= b;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding_items != 0) @(posedge clock);
   endtask

   // Build one random operand pair from a randomly chosen mix.
   task automatic send_random_item();
      logic [FIELD_BITS-1:0] a, b, swap;
      int unsigned factor, idx;
      operand_mix_type mix;
      mix = operand_mix_type'($urandom_range(MIX_CLOSE));
      if ($urandom_range(2) == 0) mix = MIX_WIDE;
      a = FIELD_BITS'($urandom);
      b = FIELD_BITS'($urandom);
      unique case (mix)
         MIX_WIDE: begin
         end
         MIX_NARROW: begin
            a = FIELD_BITS'($urandom_range(255));
            b = FIELD_BITS'($urandom_range(255));
         end
         MIX_SHARED: begin
            factor = $urandom_range(65535, 2);
            a = FIELD_BITS'(factor * $urandom_range(32'(FIELD_MAX) / factor));
            b = FIELD_BITS'(factor * $urandom_range(32'(FIELD_MAX) / factor));
         end
         MIX_FIBONACCI: begin
            idx = $urandom_range(46, 2);
            a = FIELD_BITS'(fib[idx]);
            b = FIELD_BITS'(fib[idx-1]);
         end
         MIX_ZERO: begin
            b = '0;
         end
         MIX_POWER: begin
            a = FIELD_BITS'(32'd1 << $urandom_range(FIELD_BITS - 1));
         end
         MIX_CLOSE: begin
            a = b + FIELD_BITS'($urandom_range(1));
         end
         default: begin
         end
      endcase
      // Either order, so that zero and the larger operand land on both sides.
      if ($urandom_range(1) == 1) begin
         swap = a;
         a = b;
         b = swap;
      end
      send_item(a, b);
   endtask

   initial begin
      fib[0] = 0;
      fib[1] = 1;
      for (int i = 2; i <= 46; i++) fib[i] = fib[i-1] + fib[i-2];

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed items: zero operands, extremes, worst-case Fibonacci pairs,
      // equal operands and exact multiples.
      send_item('0, '0);
      send_item(FIELD_MAX, '0);
      send_item('0, FIELD_MAX);
      send_item('0, 31'd1);
      send_item(31'd1, '0);
      send_item(31'd1, 31'd1);
      send_item(FIELD_MAX, FIELD_MAX);
      send_item(FIELD_MAX, 31'd1);
      send_item(31'd1, FIELD_MAX);
      send_item(FIELD_MAX, FIELD_MAX - 31'd1);
      send_item(FIELD_BITS'(fib[46]), FIELD_BITS'(fib[45]));
      send_item(FIELD_BITS'(fib[45]), FIELD_BITS'(fib[46]));
      send_item(31'h40000000, 31'h20000000);
      send_item(31'h55555555, 31'h2AAAAAAA);
      send_item(31'h2AAAAAAA, 31'h55555555);
      send_item(31'd1000, 31'd10);
      send_item(31'd10, 31'd1000);
      send_item(31'd240, 31'd46);
      send_item(31'd17, 31'd5);
      send_item(FIELD_MAX, 31'h40000000);
      wait_for_results();

      // Random items under each idling pattern, draining between phases.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         send_idle_pct   = sender_idle_by_phase[phase];
         recv_stall_pct <= receiver_stall_by_phase[phase];
         repeat (RANDOM_ITEMS_PER_PHASE) send_random_item();
         wait_for_results();
      end

      // Let any stray response show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding_items == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/xgcd_pkg.sv
rtl/core/xgcd_dpath.sv
rtl/core/xgcd_ctrl.sv
rtl/core/extended_gcd_bezout.sv
sim/bezout_checker.sv
sim/extended_gcd_bezout_test.sv
